// ===== rtl/assert_macros.svh =====
// Assertion macros used by the box blur top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BB_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`else
`define BB_ASSERT(label, clk, rst_n, prop, msg)
`define BB_ASSERT_IMPL(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== rtl/bbrgb_pkg.sv =====
`timescale 1ns / 1ps
// Types, constants and helpers of the 3x3 box blur.
package bbrgb_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 4096;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam int CFG_W_W = 11;
    localparam int CFG_H_W = 13;
    localparam int ROW_W   = 13;
    localparam int OUT_X_W = 10;
    localparam int OUT_Y_W = 12;
    localparam int PIX_W   = 32;
    localparam int CH_W    = 8;
    localparam int RGB_W   = 24;
    localparam int SUM_W   = 12;

    localparam logic [CFG_W_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_H_W-1:0] HEIGHT_RESET = 13'd480;

    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    // floor(s / 9) == (s * 7282) >> 16 for every 9-pixel channel sum
    localparam int               DIV9_W     = 13;
    localparam logic [DIV9_W-1:0] DIV9_MUL  = 13'd7282;
    localparam int               DIV9_SHIFT = 16;

    localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

    typedef logic [RGB_W-1:0] t_rgb;
    typedef t_rgb [2:0] t_col;
    typedef logic [SUM_W-1:0] t_sum;

    typedef struct packed {
        logic left;
        logic right;
        logic top;
        logic bottom;
    } t_win_mask;

    function automatic logic [CH_W-1:0] div9(input t_sum s);
        logic [SUM_W+DIV9_W-1:0] prod;
        prod = (SUM_W + DIV9_W)'(s) * (SUM_W + DIV9_W)'(DIV9_MUL);
        return prod[DIV9_SHIFT +: CH_W];
    endfunction

endpackage

// ===== rtl/bbrgb_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module bbrgb_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/box_blur_3x3_rgb.sv =====
`timescale 1ns / 1ps
// Top level of the streaming 3x3 RGB box blur with two line stores.
//
//  channel  handshake                     payload
//  in       i_in_valid / o_in_ready       i_mode, i_pixel_word
//  out      o_out_valid / i_out_ready     o_blurred_word, o_out_x, o_out_y, o_frame_end
//  cfg      psel / penable / pwrite       paddr, pwdata, prdata (pready tied high)
//
//  One item per clock while the output is not stalled. A result reaches the
//  output register through the read, sum and output stages; the line-store
//  RAM read returns at the transfer of the item that completes its window,
//  then the channel sum and the divide by nine are each registered.
//  Reset sets 640 x 480 and position zero; the line stores are not cleared.
//  A stalled output freezes the whole pipeline and drops o_in_ready.
`include "assert_macros.svh"
module box_blur_3x3_rgb
    import bbrgb_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_mode,
    input  logic [PIX_W-1:0]      i_pixel_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [PIX_W-1:0]      o_blurred_word,
    output logic [OUT_X_W-1:0]    o_out_x,
    output logic [OUT_Y_W-1:0]    o_out_y,
    output logic                  o_frame_end
);

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int EFF_W_W = $clog2(MAX_WIDTH + 1);

    logic [CFG_W_W-1:0] r_frame_width;
    logic [CFG_H_W-1:0] r_frame_height;
    logic [EFF_W_W-1:0] eff_w;
    logic [CFG_H_W-1:0] eff_h;
    logic               cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    logic [COL_W-1:0]   r_in_col,  n_in_col;
    logic [ROW_W-1:0]   r_in_row,  n_in_row;
    logic [COL_W-1:0]   r_em_col,  n_em_col;
    logic [OUT_Y_W-1:0] r_em_row,  n_em_row;

    logic pipe_en;
    logic xfer;
    logic take;
    logic in_frame;
    logic col_wrap;
    logic emit;
    logic em_col_wrap;
    logic em_row_last;
    logic last;
    t_win_mask mask;

    logic               r_b_valid;
    logic [COL_W-1:0]   r_b_col;
    t_rgb               r_b_pix;
    logic               r_b_emit;
    logic [OUT_X_W-1:0] r_b_x;
    logic [OUT_Y_W-1:0] r_b_y;
    logic               r_b_last;
    t_win_mask          r_b_mask;
    logic               r_b_fwd;

    logic [2*RGB_W-1:0] ram_rdata;
    t_rgb  prev_v;
    t_rgb  prev2_v;
    t_col  col_new;
    t_col  r_win_a;
    t_col  r_win_b;
    t_rgb  r_fw_prev;
    t_rgb  r_fw_prev2;
    t_col  win_cols [3];
    logic [2:0] x_ok;
    logic [2:0] y_ok;
    t_sum  sum_ch [3];

    logic               r_c_valid;
    t_sum               r_c_sum [3];
    logic [OUT_X_W-1:0] r_c_x;
    logic [OUT_Y_W-1:0] r_c_y;
    logic               r_c_last;

    logic               r_o_valid;
    logic [PIX_W-1:0]   r_o_word;
    logic [OUT_X_W-1:0] r_o_x;
    logic [OUT_Y_W-1:0] r_o_y;
    logic               r_o_last;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[CFG_W_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[CFG_H_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(r_frame_height);
        endcase
    end

    always_comb begin
        if (r_frame_width == '0) begin
            eff_w = EFF_W_W'(1);
        end else if (CFG_H_W'(r_frame_width) > CFG_H_W'(MAX_WIDTH)) begin
            eff_w = EFF_W_W'(MAX_WIDTH);
        end else begin
            eff_w = EFF_W_W'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            eff_h = CFG_H_W'(1);
        end else if (r_frame_height > CFG_H_W'(MAX_HEIGHT)) begin
            eff_h = CFG_H_W'(MAX_HEIGHT);
        end else begin
            eff_h = r_frame_height;
        end
    end

    // input side: positions, read issue
    assign pipe_en     = !r_o_valid || i_out_ready;
    assign o_in_ready  = pipe_en;
    assign xfer        = i_in_valid && o_in_ready;
    assign in_frame    = r_in_row < eff_h;
    assign take        = xfer && !(in_frame && (i_mode == MODE_FLUSH));
    assign col_wrap    = (EFF_W_W'(r_in_col) + EFF_W_W'(1)) == eff_w;
    assign emit        = (r_in_row >= ROW_W'(2))
                      || ((r_in_row == ROW_W'(1)) && (r_in_col != '0));
    assign em_col_wrap = (EFF_W_W'(r_em_col) + EFF_W_W'(1)) == eff_w;
    assign em_row_last = (CFG_H_W'(r_em_row) + CFG_H_W'(1)) == eff_h;
    assign last        = em_col_wrap && em_row_last;

    assign mask.left   = r_em_col != '0;
    assign mask.right  = !em_col_wrap;
    assign mask.top    = r_em_row != '0;
    assign mask.bottom = !em_row_last;

    always_comb begin
        n_in_col = r_in_col;
        n_in_row = r_in_row;
        n_em_col = r_em_col;
        n_em_row = r_em_row;
        if (cfg_wr) begin
            n_in_col = '0;
            n_in_row = '0;
            n_em_col = '0;
            n_em_row = '0;
        end else if (take) begin
            if (col_wrap) begin
                n_in_col = '0;
                n_in_row = r_in_row + ROW_W'(1);
            end else begin
                n_in_col = r_in_col + COL_W'(1);
            end
            if (emit) begin
                if (em_col_wrap) begin
                    n_em_col = '0;
                    n_em_row = r_em_row + OUT_Y_W'(1);
                end else begin
                    n_em_col = r_em_col + COL_W'(1);
                end
                if (last) begin
                    n_in_col = '0;
                    n_in_row = '0;
                    n_em_col = '0;
                    n_em_row = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col <= '0;
            r_in_row <= '0;
            r_em_col <= '0;
            r_em_row <= '0;
        end else begin
            r_in_col <= n_in_col;
            r_in_row <= n_in_row;
            r_em_col <= n_em_col;
            r_em_row <= n_em_row;
        end
    end

    // read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (pipe_en) begin
            r_b_valid <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_b_col  <= r_in_col;
            r_b_pix  <= in_frame ? i_pixel_word[PIX_W-1 -: RGB_W] : '0;
            r_b_emit <= emit;
            r_b_x    <= OUT_X_W'(r_em_col);
            r_b_y    <= r_em_row;
            r_b_last <= last;
            r_b_mask <= mask;
            r_b_fwd  <= r_b_valid && (r_b_col == r_in_col);
        end
    end

    bbrgb_ram #(
        .WIDTH (2 * RGB_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (pipe_en && r_b_valid),
        .i_waddr (r_b_col),
        .i_wdata ({prev_v, r_b_pix}),
        .i_re    (take),
        .i_raddr (r_in_col),
        .o_rdata (ram_rdata)
    );

    // window and channel sums
    assign prev_v  = r_b_fwd ? r_fw_prev  : ram_rdata[RGB_W-1:0];
    assign prev2_v = r_b_fwd ? r_fw_prev2 : ram_rdata[2*RGB_W-1:RGB_W];
    assign col_new = {r_b_pix, prev_v, prev2_v};

    always_ff @(posedge i_clk) begin
        if (pipe_en && r_b_valid) begin
            r_win_a    <= r_win_b;
            r_win_b    <= col_new;
            r_fw_prev  <= r_b_pix;
            r_fw_prev2 <= prev_v;
        end
    end

    always_comb begin
        win_cols[0] = r_win_a;
        win_cols[1] = r_win_b;
        win_cols[2] = col_new;
        x_ok = {r_b_mask.right, 1'b1, r_b_mask.left};
        y_ok = {r_b_mask.bottom, 1'b1, r_b_mask.top};
        for (int ch = 0; ch < 3; ch++) begin
            sum_ch[ch] = '0;
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    if (x_ok[k] && y_ok[j]) begin
                        sum_ch[ch] = sum_ch[ch]
                                   + SUM_W'(win_cols[k][j][ch*CH_W +: CH_W]);
                    end
                end
            end
        end
    end

    // sum stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (pipe_en) begin
            r_c_valid <= r_b_valid && r_b_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_c_sum  <= sum_ch;
            r_c_x    <= r_b_x;
            r_c_y    <= r_b_y;
            r_c_last <= r_b_last;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (pipe_en) begin
            r_o_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_o_word <= {div9(r_c_sum[2]), div9(r_c_sum[1]), div9(r_c_sum[0]), ALPHA_OPAQUE};
            r_o_x    <= r_c_x;
            r_o_y    <= r_c_y;
            r_o_last <= r_c_last;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_blurred_word = r_o_word;
    assign o_out_x        = r_o_x;
    assign o_out_y        = r_o_y;
    assign o_frame_end    = r_o_last;

    `BB_ASSERT(a_in_col_range, i_clk, i_rst_n, EFF_W_W'(r_in_col) < eff_w, "input column beyond width")
    `BB_ASSERT(a_em_row_range, i_clk, i_rst_n, CFG_H_W'(r_em_row) < eff_h, "emit row beyond height")
    `BB_ASSERT_IMPL(a_frame_end_pos, i_clk, i_rst_n, o_out_valid && o_frame_end, (o_out_x == OUT_X_W'(eff_w - EFF_W_W'(1))) && (o_out_y == OUT_Y_W'(eff_h - CFG_H_W'(1))), "frame end off the last pixel")

endmodule

// ===== tb/box_blur_3x3_rgb_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the streaming 3x3 RGB box blur.
module box_blur_3x3_rgb_tb;
    import bbrgb_pkg::*;

    localparam int   TAIL_CYCLES = 8;

    typedef struct packed {
        logic [PIX_W-1:0]   word;
        logic [OUT_X_W-1:0] x;
        logic [OUT_Y_W-1:0] y;
        logic               fe;
    } t_blur_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_mode;
    logic [PIX_W-1:0]      i_pixel_word;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [PIX_W-1:0]      o_blurred_word;
    logic [OUT_X_W-1:0]    o_out_x;
    logic [OUT_Y_W-1:0]    o_out_y;
    logic                  o_frame_end;

    box_blur_3x3_rgb u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_pixel_word  (i_pixel_word),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_blurred_word(o_blurred_word),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_frame_end   (o_frame_end)
    );

    t_blur_result       pending_blur [$];
    t_blur_result       want;
    int                 fail_count;
    bit                 calm;

    logic [CFG_W_W-1:0] width_reg;
    logic [CFG_H_W-1:0] height_reg;
    t_rgb               line_above1 [MAX_WIDTH_DEF];
    t_rgb               line_above2 [MAX_WIDTH_DEF];
    t_col               win [3];
    int                 in_x;
    int                 in_y;
    int                 emit_x;
    int                 emit_y;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int active_width();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return int'(width_reg);
    endfunction

    function automatic int active_height();
        if (height_reg == 0) return 1;
        if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
        return int'(height_reg);
    endfunction

    function automatic void restart_frame();
        win[0] = '0;
        win[1] = '0;
        win[2] = '0;
        in_x = 0;
        in_y = 0;
        emit_x = 0;
        emit_y = 0;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic blur_step(input logic mode, input logic [PIX_W-1:0] pix);
        int w, h, col, row, k, j, px, py, sr, sg, sb;
        t_col fresh;
        t_col nb [3];
        logic emit, last;
        t_blur_result res;
        w = active_width();
        h = active_height();
        col = in_x;
        row = in_y;
        if (row < h && mode == MODE_FLUSH) return;
        fresh = '0;
        if (row <= h) begin
            fresh[0] = line_above2[col];
            fresh[1] = line_above1[col];
            if (row < h) fresh[2] = pix[PIX_W-1:CH_W];
            line_above2[col] = fresh[1];
            line_above1[col] = fresh[2];
        end
        nb[0] = win[1];
        nb[1] = win[2];
        if (col == 0) begin
            nb[2] = '0;
            win[0] = '0;
            win[1] = '0;
            win[2] = fresh;
        end else begin
            nb[2] = fresh;
            win[0] = nb[0];
            win[1] = nb[1];
            win[2] = nb[2];
        end
        emit = (row >= 2) || (row == 1 && col >= 1);
        col++;
        if (col >= w) begin
            col = 0;
            row++;
        end
        in_x = col;
        in_y = row;
        if (!emit) return;
        last = (emit_x + 1 == w) && (emit_y + 1 == h);
        sr = 0;
        sg = 0;
        sb = 0;
        for (k = 0; k < 3; k++) begin
            px = emit_x - 1 + k;
            if (px < 0 || px >= w) continue;
            for (j = 0; j < 3; j++) begin
                py = emit_y - 1 + j;
                if (py < 0 || py >= h) continue;
                sr += nb[k][j][23:16];
                sg += nb[k][j][15:8];
                sb += nb[k][j][7:0];
            end
        end
        res.word = {8'(sr / 9), 8'(sg / 9), 8'(sb / 9), ALPHA_OPAQUE};
        res.x = OUT_X_W'(emit_x);
        res.y = OUT_Y_W'(emit_y);
        res.fe = last;
        pending_blur.push_back(res);
        emit_x++;
        if (emit_x >= w) begin
            emit_x = 0;
            emit_y++;
        end
        if (last) restart_frame();
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_FRAME_WIDTH) width_reg = value[CFG_W_W-1:0];
        else height_reg = value[CFG_H_W-1:0];
        restart_frame();
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_item(input logic mode, input logic [PIX_W-1:0] pix);
        int gap;
        i_in_valid <= 1'b1;
        i_mode <= mode;
        i_pixel_word <= pix;
        do @(posedge i_clk); while (!o_in_ready);
        blur_step(mode, pix);
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic stop_input();
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_results();
        while (pending_blur.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_frame(input int pixels, input int drain);
        int i;
        for (i = 0; i < pixels; i++) send_item(MODE_PIXEL, $urandom());
        for (i = 0; i < drain; i++) send_item(1'($urandom_range(0, 1)), $urandom());
        stop_input();
        wait_results();
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] exp_v,
                                   input logic [31:0] act_v);
        fail_count++;
        if (fail_count <= 100)
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, exp_v, act_v);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && $isunknown(o_out_valid))
            report_mismatch("o_out_valid", 32'd0, {31'd0, o_out_valid});
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_blur.size() == 0) begin
                report_mismatch("unexpected result", 32'd0, o_blurred_word);
            end else begin
                want = pending_blur.pop_front();
                if (o_blurred_word !== want.word)
                    report_mismatch("blurred_word", want.word, o_blurred_word);
                if (o_out_x !== want.x)
                    report_mismatch("out_x", 32'(want.x), 32'(o_out_x));
                if (o_out_y !== want.y)
                    report_mismatch("out_y", 32'(want.y), 32'(o_out_y));
                if (o_frame_end !== want.fe)
                    report_mismatch("frame_end", 32'(want.fe), 32'(o_frame_end));
            end
        end
    end

    initial begin
        int stall;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            stall = pick_gap();
            if (stall == 0) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic test_reset_size();
        int i;
        for (i = 0; i < 645; i++) begin
            if (i == 643) begin
                stop_input();
                wait_results();
            end
            send_item(MODE_PIXEL, $urandom());
        end
        stop_input();
        wait_results();
    endtask

    task automatic test_directed();
        write_reg(REG_FRAME_WIDTH, 32'd3);
        write_reg(REG_FRAME_HEIGHT, 32'd3);
        send_item(MODE_PIXEL, 32'hFFFF_FFFF);
        send_item(MODE_PIXEL, 32'h0000_0000);
        send_item(MODE_PIXEL, 32'hFF00_00AA);
        send_item(MODE_FLUSH, 32'hFFFF_FFFF);
        send_item(MODE_PIXEL, 32'h00FF_0055);
        send_item(MODE_PIXEL, 32'h0000_FF00);
        send_item(MODE_PIXEL, 32'hFFFF_FF00);
        send_item(MODE_FLUSH, 32'h0000_0000);
        send_item(MODE_PIXEL, 32'h1234_5678);
        send_item(MODE_PIXEL, 32'h8080_8001);
        send_item(MODE_PIXEL, 32'h7F7F_7F7E);
        send_item(MODE_FLUSH, 32'h0000_0000);
        send_item(MODE_PIXEL, 32'hFFFF_FFFF);
        send_item(MODE_FLUSH, 32'h0000_0000);
        send_item(MODE_FLUSH, 32'h0000_0000);
        send_item(MODE_FLUSH, 32'h0000_0000);
        stop_input();
        wait_results();
        write_reg(REG_FRAME_WIDTH, 32'd1);
        write_reg(REG_FRAME_HEIGHT, 32'd1);
        send_item(MODE_PIXEL, 32'hFFFF_FFFF);
        send_item(MODE_FLUSH, 32'h0000_0000);
        send_item(MODE_PIXEL, 32'hDEAD_BEEF);
        send_item(MODE_FLUSH, 32'hFFFF_FFFF);
        stop_input();
        wait_results();
    endtask

    task automatic test_size_extremes();
        write_reg(REG_FRAME_WIDTH, 32'd0);
        write_reg(REG_FRAME_HEIGHT, 32'd0);
        send_frame(1, 2);
    endtask

    task automatic test_random_frames();
        int sent, npix, cut, f, i, nfr;
        int unsigned w, h;
        sent = 0;
        while (sent < 470) begin
            w = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 6);
            h = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : $urandom_range(1, 5);
            calm = ($urandom_range(0, 4) == 0);
            write_reg(REG_FRAME_WIDTH, w | ($urandom() << CFG_W_W));
            write_reg(REG_FRAME_HEIGHT, h | ($urandom() << CFG_H_W));
            nfr = $urandom_range(1, 3);
            for (f = 0; f < nfr; f++) begin
                npix = w * h;
                cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, npix - 1) : npix;
                for (i = 0; i < cut; i++) begin
                    if ($urandom_range(0, 9) == 0) send_item(MODE_FLUSH, $urandom());
                    send_item(MODE_PIXEL, $urandom());
                    sent++;
                    if ($urandom_range(0, 199) == 0) begin
                        stop_input();
                        wait_results();
                    end
                end
                if (cut < npix) break;
                for (i = 0; i <= w; i++) begin
                    send_item(1'($urandom_range(0, 1)), $urandom());
                    sent++;
                end
            end
            stop_input();
            wait_results();
        end
        calm = 1'b0;
    endtask

    initial begin
        int i;
        int tail;
        fail_count = 0;
        calm = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_in_valid = 1'b0;
        i_mode = MODE_PIXEL;
        i_pixel_word = '0;
        width_reg = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        for (i = 0; i < MAX_WIDTH_DEF; i++) begin
            line_above1[i] = '0;
            line_above2[i] = '0;
        end
        restart_frame();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_size();
        test_directed();
        test_size_extremes();
        test_random_frames();

        stop_input();
        for (tail = 0; tail < 5000 && pending_blur.size() != 0; tail++) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (pending_blur.size() != 0) begin
            fail_count++;
            $display("%0t: %0d expected results never arrived", $time, pending_blur.size());
        end
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #100_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== box_blur_3x3_rgb.f =====
+incdir+rtl
rtl/bbrgb_pkg.sv
rtl/bbrgb_ram.sv
rtl/box_blur_3x3_rgb.sv
tb/box_blur_3x3_rgb_tb.sv
